>>> hdl/bad_pkg.sv
// Package for the block-average downscaler: frame and block geometry,
// derived widths, reciprocal constants for the block-area divide, word types.
// No dependencies.
`default_nettype none

package bad_pkg;

    localparam int SRC_WIDTH  = 160;
    localparam int SRC_HEIGHT = 120;
    localparam int BLOCK_W    = 5;
    localparam int BLOCK_H    = 4;

    localparam int OUT_COLS   = SRC_WIDTH / BLOCK_W;
    localparam int OUT_ROWS   = SRC_HEIGHT / BLOCK_H;
    localparam int BLOCK_AREA = BLOCK_W * BLOCK_H;

    localparam int PIX_W = 8;

    localparam int COL_W  = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
    localparam int ROW_W  = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int DX_W   = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
    localparam int RIB_W  = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;
    localparam int BLK_W  = $clog2(OUT_COLS + 1);
    localparam int BAND_W = $clog2(OUT_ROWS + 1);
    localparam int IDX_W  = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;

    localparam int SUM_W = $clog2(BLOCK_AREA * ((1 << PIX_W) - 1) + 1);

    // floor(x / BLOCK_AREA) == (x * RECIP_MULT) >> RECIP_SHIFT for x < 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + $clog2(BLOCK_AREA);
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + BLOCK_AREA - 1) / BLOCK_AREA;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic [PIX_W-1:0] pix_red;
        logic [PIX_W-1:0] pix_green;
        logic [PIX_W-1:0] pix_blue;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] avg_red;
        logic [PIX_W-1:0] avg_green;
        logic [PIX_W-1:0] avg_blue;
        logic             frame_done;
    } avg_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

endpackage

`default_nettype wire

>>> hdl/block_average_downscaler.sv
// Block-average downscaler: one pixel word per cycle in, one averaged word out
// per completed block. avg_valid follows the block's last pixel through the sum
// register, then the reciprocal multiply into the output register.
// Throughput 1 pixel per cycle; pix_ready drops only when both stages hold a word.
// Reset clears position counters and valid flags; column sums are not reset.
// Depends on bad_pkg.
`default_nettype none

module block_average_downscaler (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pix_valid,
    output logic               pix_ready,
    input  wire bad_pkg::pix_t pix_data,
    output logic               avg_valid,
    input  wire logic          avg_ready,
    output bad_pkg::avg_t      avg_data
);
    import bad_pkg::*;

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [DX_W-1:0]   dx_reg,   dx_next;
    logic [RIB_W-1:0]  rib_reg,  rib_next;
    logic [BLK_W-1:0]  blk_reg,  blk_next;
    logic [BAND_W-1:0] band_reg, band_next;

    sum_t col_sum_reg [OUT_COLS];

    logic             s1_valid_reg, s1_valid_next;
    sum_t             s1_sum_reg;
    logic             s1_last_reg;
    logic             avg_valid_reg, avg_valid_next;
    avg_t             avg_data_reg, avg_data_next;

    logic             accept;
    logic             in_block;
    logic             fresh;
    logic             emit;
    logic             last_block;
    logic [IDX_W-1:0] idx;
    sum_t             old_sum;
    sum_t             new_sum;
    logic             out_open;
    logic             s1_open;

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod_red;
    logic [PROD_W-1:0]  prod_green;
    logic [PROD_W-1:0]  prod_blue;

    assign out_open  = !avg_valid_reg || avg_ready;
    assign s1_open   = !s1_valid_reg || out_open;
    assign pix_ready = s1_open;
    assign accept    = pix_valid && pix_ready;

    assign idx      = blk_reg[IDX_W-1:0];
    assign in_block = (blk_reg < BLK_W'(OUT_COLS)) && (band_reg < BAND_W'(OUT_ROWS));
    assign fresh    = (rib_reg == '0) && (dx_reg == '0);
    assign emit     = in_block && (rib_reg == RIB_W'(BLOCK_H - 1))
                      && (dx_reg == DX_W'(BLOCK_W - 1));
    assign last_block = (blk_reg == BLK_W'(OUT_COLS - 1))
                        && (band_reg == BAND_W'(OUT_ROWS - 1));

    always_comb
    begin
        old_sum = fresh ? '0 : col_sum_reg[idx];
        new_sum.red   = old_sum.red   + SUM_W'(pix_data.pix_red);
        new_sum.green = old_sum.green + SUM_W'(pix_data.pix_green);
        new_sum.blue  = old_sum.blue  + SUM_W'(pix_data.pix_blue);
    end

    // advance raster position
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        dx_next   = dx_reg;
        rib_next  = rib_reg;
        blk_next  = blk_reg;
        band_next = band_reg;
        if (accept)
        begin
            if (col_reg == COL_W'(SRC_WIDTH - 1))
            begin
                col_next = '0;
                dx_next  = '0;
                blk_next = '0;
                if (row_reg == ROW_W'(SRC_HEIGHT - 1))
                begin
                    row_next  = '0;
                    rib_next  = '0;
                    band_next = '0;
                end
                else if (rib_reg == RIB_W'(BLOCK_H - 1))
                begin
                    row_next  = row_reg + 1'b1;
                    rib_next  = '0;
                    band_next = band_reg + 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    rib_next = rib_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (dx_reg == DX_W'(BLOCK_W - 1))
                begin
                    dx_next  = '0;
                    blk_next = blk_reg + 1'b1;
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
        end
    end

    assign recip      = RECIP_W'(RECIP_MULT);
    assign prod_red   = PROD_W'(s1_sum_reg.red)   * PROD_W'(recip);
    assign prod_green = PROD_W'(s1_sum_reg.green) * PROD_W'(recip);
    assign prod_blue  = PROD_W'(s1_sum_reg.blue)  * PROD_W'(recip);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        avg_valid_next = avg_valid_reg;
        if (s1_open)
        begin
            s1_valid_next = accept && emit;
        end
        if (out_open)
        begin
            avg_valid_next = s1_valid_reg;
        end
        avg_data_next.avg_red    = prod_red[RECIP_SHIFT +: PIX_W];
        avg_data_next.avg_green  = prod_green[RECIP_SHIFT +: PIX_W];
        avg_data_next.avg_blue   = prod_blue[RECIP_SHIFT +: PIX_W];
        avg_data_next.frame_done = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            dx_reg        <= '0;
            rib_reg       <= '0;
            blk_reg       <= '0;
            band_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            dx_reg        <= dx_next;
            rib_reg       <= rib_next;
            blk_reg       <= blk_next;
            band_reg      <= band_next;
            s1_valid_reg  <= s1_valid_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_block)
        begin
            col_sum_reg[idx] <= new_sum;
        end
        if (s1_open && accept && emit)
        begin
            s1_sum_reg  <= new_sum;
            s1_last_reg <= last_block;
        end
        if (out_open && s1_valid_reg)
        begin
            avg_data_reg <= avg_data_next;
        end
    end

    assign avg_valid = avg_valid_reg;
    assign avg_data  = avg_data_reg;

    a_ready_low_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> (s1_valid_reg && avg_valid_reg))
        else $error("pix_ready low while a stage is free");

    a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |-> $past(pix_valid && pix_ready))
        else $error("sum stage loaded without an accepted pixel");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (col_reg == COL_W'(SRC_WIDTH - 1)))
        |=> ((col_reg == '0) && (dx_reg == '0) && (blk_reg == '0)))
        else $error("column counters did not wrap at end of row");

    a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_reg <= BLK_W'(OUT_COLS)) && (band_reg <= BAND_W'(OUT_ROWS)))
        else $error("block or band index out of range");

endmodule

`default_nettype wire
